@@ hdl/sacl_pkg.sv @@
// ----------------------------------------------------------------------------
// sacl_pkg: shared types and codes for the set-associative LRU cache model
// Holds the request opcodes, register indexes, sequencer states and the
// result of the shared way compare unit.
// ----------------------------------------------------------------------------
package sacl_pkg;

  // Width of the running totals.
  localparam int TOTAL_W = 32;

  // Configuration port geometry.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 5;

  // Reset values of the configuration registers.
  localparam logic [2:0] SET_BITS_RESET    = 3'd4;
  localparam logic [4:0] OFFSET_BITS_RESET = 5'd4;
  localparam logic [2:0] WAYS_RESET        = 3'd4;

  // Request opcodes.
  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_MODIFY = 2'd2,
    OP_IFETCH = 2'd3
  } opcode_t;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SET_BITS    = 2'd0,
    REG_OFFSET_BITS = 2'd1,
    REG_WAYS        = 2'd2
  } cfg_reg_t;

  // Lookup sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_EVAL,
    ST_FINISH
  } state_t;

  // Verdict of the way compare unit for the way under test.
  typedef struct packed {
    logic free;   // way is invalid and ends the search
    logic hit;    // way is valid and its tag matches
    logic older;  // way is the oldest seen so far in this search
  } way_cmp_t;

endpackage

@@ hdl/set_assoc_lru_cache_sim_core.sv @@
// A request is taken in IDLE and goes through DECODE, then READ and EVAL for each
// way searched, and its result is loaded in FINISH; an instruction fetch gives none.
// A new request is taken only back in IDLE; FINISH waits while a result is stalled.
// The search uses the single read port of the tag/stamp memories and the shared
// compare unit, one way at a time (read, then evaluate; the chosen way is written).
// Reset (synchronous) clears the valid bits, totals, clock and registers at once.
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim_core: set-associative cache with LRU replacement
// Looks up each request address in a small cache model, way by way, and
// reports hits, misses, evictions and the running totals.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim_core
  import sacl_pkg::*;
#(
  parameter int MAX_SET_BITS = 6,
  parameter int WAYS         = 4,
  parameter int ADDR_BITS    = 48,
  parameter int STAMP_BITS   = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration port
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // Request channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             opcode,
  input  logic [ADDR_BITS-1:0]   address,
  // Result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             hits,
  output logic                   missed,
  output logic                   evicted,
  output logic [TOTAL_W-1:0]     total_hits,
  output logic [TOTAL_W-1:0]     total_misses,
  output logic [TOTAL_W-1:0]     total_evictions
);

  localparam int SET_IW    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int NUM_SETS  = 1 << MAX_SET_BITS;
  localparam int NUM_LINES = NUM_SETS * WAYS;
  localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int LINE_W    = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;

  // Configuration registers
  logic [2:0] set_bits;
  logic [4:0] offset_bits;
  logic [2:0] ways_in_use;

  // Sequencer
  state_t state, state_next;
  logic   rd_en, wr_en, finish_load;

  // Request and search registers
  opcode_t               op_q;
  logic [ADDR_BITS-1:0]  addr_q;
  logic [SET_IW-1:0]     set_q;
  logic [ADDR_BITS-1:0]  tag_q;
  logic [WAY_W-1:0]      way;
  logic [WAY_W-1:0]      way_last;
  logic [WAY_W-1:0]      victim_q;
  logic [STAMP_BITS-1:0] best_age;
  logic                  have_victim;
  logic                  hit_q, evict_q;

  // Decode results
  logic [SET_IW-1:0]    set_calc;
  logic [ADDR_BITS-1:0] tag_calc;
  logic [WAY_W-1:0]     way_last_calc;

  // Line store
  logic [NUM_LINES-1:0]  line_valid;
  logic [ADDR_BITS-1:0]  tag_mem   [NUM_LINES];
  logic [STAMP_BITS-1:0] stamp_mem [NUM_LINES];
  logic                  valid_rd;
  logic [ADDR_BITS-1:0]  tag_rd;
  logic [STAMP_BITS-1:0] stamp_rd;
  logic [LINE_W-1:0]     rd_line, wr_line;
  logic [WAY_W-1:0]      wr_way;

  // Counters
  logic [STAMP_BITS-1:0] access_clock;
  logic [TOTAL_W-1:0]    hit_total, miss_total, evict_total;

  // Compare unit outputs
  way_cmp_t              verdict;
  logic [STAMP_BITS-1:0] age;
  logic [WAY_W-1:0]      victim_sel;
  logic [1:0]            hits_calc;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= SET_BITS_RESET;
      offset_bits <= OFFSET_BITS_RESET;
      ways_in_use <= WAYS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SET_BITS:    set_bits    <= cfg_data[2:0];
        REG_OFFSET_BITS: offset_bits <= cfg_data;
        REG_WAYS:        ways_in_use <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Address decode under the clamped geometry.
  always_comb begin
    logic [3:0]           sb;
    logic [5:0]           shamt;
    logic [ADDR_BITS-1:0] set_shift;
    int                   nw;
    if (int'(set_bits) > MAX_SET_BITS) begin
      sb = 4'(MAX_SET_BITS);
    end else begin
      sb = {1'b0, set_bits};
    end
    shamt     = {2'b00, sb} + {1'b0, offset_bits};
    set_shift = addr_q >> offset_bits;
    for (int i = 0; i < SET_IW; i++) begin
      set_calc[i] = set_shift[i] & (i < int'(sb));
    end
    tag_calc = addr_q >> shamt;
    if (ways_in_use == 3'd0) begin
      nw = 1;
    end else if (int'(ways_in_use) > WAYS) begin
      nw = WAYS;
    end else begin
      nw = int'(ways_in_use);
    end
    way_last_calc = WAY_W'(nw - 1);
  end

  // Shared compare unit, used once per way.
  sacl_way_cmp #(
    .ADDR_BITS  (ADDR_BITS),
    .STAMP_BITS (STAMP_BITS)
  ) u_way_cmp (
    .line_ok     (valid_rd),
    .line_tag    (tag_rd),
    .key_tag     (tag_q),
    .line_stamp  (stamp_rd),
    .now_stamp   (access_clock),
    .best_age    (best_age),
    .have_victim (have_victim),
    .verdict     (verdict),
    .age         (age)
  );

  assign victim_sel = verdict.older ? way : victim_q;
  assign rd_line    = LINE_W'(int'(set_q) * WAYS + int'(way));
  assign wr_line    = LINE_W'(int'(set_q) * WAYS + int'(wr_way));
  assign hits_calc  = {1'b0, hit_q} + {1'b0, (op_q == OP_MODIFY)};

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control.
  always_comb begin
    state_next  = state;
    in_stall    = (state != ST_IDLE);
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_way      = way;
    finish_load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && (opcode != OP_IFETCH)) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_next = ST_READ;
      end
      ST_READ: begin
        rd_en      = 1'b1;
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        priority if (verdict.free || verdict.hit) begin
          wr_en      = 1'b1;
          state_next = ST_FINISH;
        end else if (way == way_last) begin
          wr_en      = 1'b1;
          wr_way     = victim_sel;
          state_next = ST_FINISH;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          finish_load = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Request capture and search bookkeeping.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          op_q   <= opcode_t'(opcode);
          addr_q <= address;
        end
      end
      ST_DECODE: begin
        set_q       <= set_calc;
        tag_q       <= tag_calc;
        way_last    <= way_last_calc;
        way         <= '0;
        victim_q    <= '0;
        best_age    <= '0;
        have_victim <= 1'b0;
      end
      ST_EVAL: begin
        hit_q   <= verdict.hit;
        evict_q <= !(verdict.free || verdict.hit);
        if (!(verdict.free || verdict.hit) && (way != way_last)) begin
          way <= way + 1'b1;
          if (verdict.older) begin
            have_victim <= 1'b1;
            best_age    <= age;
            victim_q    <= way;
          end
        end
      end
      default: ;
    endcase
  end

  // Tag and stamp memories: one write and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag_mem[wr_line]   <= tag_q;
      stamp_mem[wr_line] <= access_clock;
    end
    if (rd_en) begin
      tag_rd   <= tag_mem[rd_line];
      stamp_rd <= stamp_mem[rd_line];
      valid_rd <= line_valid[rd_line];
    end
  end

  // Valid bits, cleared at once by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid <= '0;
    end else if (wr_en) begin
      line_valid[wr_line] <= 1'b1;
    end
  end

  // Running totals, access clock and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      access_clock <= '0;
      hit_total    <= '0;
      miss_total   <= '0;
      evict_total  <= '0;
    end else if (finish_load) begin
      out_valid    <= 1'b1;
      access_clock <= access_clock + 1'b1;
      hit_total    <= hit_total + TOTAL_W'(hits_calc);
      miss_total   <= miss_total + TOTAL_W'(!hit_q);
      evict_total  <= evict_total + TOTAL_W'(evict_q);
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_load) begin
      hits            <= hits_calc;
      missed          <= !hit_q;
      evicted         <= evict_q;
      total_hits      <= hit_total + TOTAL_W'(hits_calc);
      total_misses    <= miss_total + TOTAL_W'(!hit_q);
      total_evictions <= evict_total + TOTAL_W'(evict_q);
    end
  end

endmodule

@@ hdl/sacl_way_cmp.sv @@
// ----------------------------------------------------------------------------
// sacl_way_cmp: shared compare unit of the lookup sequencer
// Tests one way at a time: free line, tag match, and whether its age beats the
// oldest age found so far in the set.
// ----------------------------------------------------------------------------
module sacl_way_cmp
  import sacl_pkg::*;
#(
  parameter int ADDR_BITS  = 48,
  parameter int STAMP_BITS = 32
) (
  input  logic                  line_ok,
  input  logic [ADDR_BITS-1:0]  line_tag,
  input  logic [ADDR_BITS-1:0]  key_tag,
  input  logic [STAMP_BITS-1:0] line_stamp,
  input  logic [STAMP_BITS-1:0] now_stamp,
  input  logic [STAMP_BITS-1:0] best_age,
  input  logic                  have_victim,
  output way_cmp_t              verdict,
  output logic [STAMP_BITS-1:0] age
);

  // Age wraps with the access clock; ties keep the lower way.
  always_comb begin
    age           = now_stamp - line_stamp;
    verdict.free  = !line_ok;
    verdict.hit   = line_ok && (line_tag == key_tag);
    verdict.older = !have_victim || (age > best_age);
  end

endmodule

@@ hdl/sacl_checker.sv @@
// ----------------------------------------------------------------------------
// sacl_checker: port-level checks for the cache model core
// Watches the request and result channels and the result fields over time.
// ----------------------------------------------------------------------------
module sacl_checker
  import sacl_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic [1:0]         opcode,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         hits,
  input logic               missed,
  input logic               evicted,
  input logic [TOTAL_W-1:0] total_hits
);

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hits) && $stable(total_hits))
    else $error("stalled result changed or dropped");

  // A taken load, store or modify occupies the sequencer in the next cycle.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (opcode != OP_IFETCH) |=> in_stall)
    else $error("request side not busy after a lookup request");

  // A miss leaves at most the second hit of a modify; no miss means a hit.
  a_hits_vs_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (missed ? (hits != 2'd2) : (hits != 2'd0)) && (hits != 2'd3))
    else $error("hit count inconsistent with miss flag");

  // An eviction only happens on a miss.
  a_evict_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && evicted |-> missed)
    else $error("eviction reported on a hit");

endmodule

bind set_assoc_lru_cache_sim_core sacl_checker u_sacl_checker (.*);

@@ verif/set_assoc_lru_cache_sim_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim_core_tb: self-checking bench for the LRU cache core
// Drives load, store, modify and fetch requests under several cache
// geometries, predicts each hit, miss and eviction with a local model of the
// cache, and compares every result field against that prediction.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim_core_tb;
  import sacl_pkg::*;

  localparam int ADDR_W        = 48;
  localparam int MAX_SETB      = 6;
  localparam int WAYS_N        = 4;
  localparam int NUM_LINES     = (1 << MAX_SETB) * WAYS_N;
  // Settle wait after draining; allows margin beyond the longest search of four ways.
  localparam int SETTLE_CYCLES = 16;

  // One expected result of a load, store or modify.
  typedef struct {
    logic [1:0]         hits;
    logic               missed;
    logic               evicted;
    logic [TOTAL_W-1:0] total_hits;
    logic [TOTAL_W-1:0] total_misses;
    logic [TOTAL_W-1:0] total_evictions;
  } access_result_t;

  // Clock, reset and block ports.
  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  logic [1:0]             opcode    = OP_LOAD;
  logic [ADDR_W-1:0]      address   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [1:0]             hits;
  logic                   missed;
  logic                   evicted;
  logic [TOTAL_W-1:0]     total_hits;
  logic [TOTAL_W-1:0]     total_misses;
  logic [TOTAL_W-1:0]     total_evictions;

  // Local copy of the cache contents, totals and geometry.
  bit                 line_valid [NUM_LINES];
  logic [ADDR_W-1:0]  line_tag   [NUM_LINES];
  logic [31:0]        line_stamp [NUM_LINES];
  logic [31:0]        access_clock;
  logic [TOTAL_W-1:0] hit_total;
  logic [TOTAL_W-1:0] miss_total;
  logic [TOTAL_W-1:0] evict_total;
  logic [2:0]         cfg_set_bits;
  logic [4:0]         cfg_offset_bits;
  logic [2:0]         cfg_ways;

  access_result_t pending_results [$];
  int unsigned    mismatch_count = 0;
  int unsigned    burst_left     = 1;
  int unsigned    stall_tick     = 0;
  int unsigned    stall_mode     = 0;

  set_assoc_lru_cache_sim_core DUT (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .opcode          (opcode),
    .address         (address),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .hits            (hits),
    .missed          (missed),
    .evicted         (evicted),
    .total_hits      (total_hits),
    .total_misses    (total_misses),
    .total_evictions (total_evictions)
  );

  always #6 clk = ~clk;

  // Put the local cache model into its post-reset state.
  task automatic reset_model();
    for (int i = 0; i < NUM_LINES; i++) begin
      line_valid[i] = 1'b0;
      line_tag[i]   = '0;
      line_stamp[i] = '0;
    end
    access_clock    = '0;
    hit_total       = '0;
    miss_total      = '0;
    evict_total     = '0;
    cfg_set_bits    = SET_BITS_RESET;
    cfg_offset_bits = OFFSET_BITS_RESET;
    cfg_ways        = WAYS_RESET;
  endtask

  function automatic int unsigned active_set_bits();
    return (32'(cfg_set_bits) > MAX_SETB) ? MAX_SETB : 32'(cfg_set_bits);
  endfunction

  // One lookup of the model; returns 1 on a hit and flags replacement of a valid line.
  function automatic bit cache_lookup(input logic [ADDR_W-1:0] a, output bit evict);
    int unsigned       sb, ob, nw, base, slot, victim;
    logic [ADDR_W-1:0] one, set_idx, tag;
    logic [31:0]       age, oldest_age;
    bit                have_victim;
    evict       = 1'b0;
    have_victim = 1'b0;
    oldest_age  = '0;
    one         = ADDR_W'(1);
    sb          = active_set_bits();
    ob          = 32'(cfg_offset_bits);
    nw          = (cfg_ways == 0) ? 1 : ((32'(cfg_ways) > WAYS_N) ? WAYS_N : 32'(cfg_ways));
    set_idx     = (a >> ob) & ((one << sb) - one);
    tag         = a >> (sb + ob);
    base        = 32'(set_idx) * WAYS_N;
    victim      = base;
    for (int w = 0; w < nw; w++) begin
      slot = base + w;
      // A free way ends the search and is filled.
      if (!line_valid[slot]) begin
        line_valid[slot] = 1'b1;
        line_tag[slot]   = tag;
        line_stamp[slot] = access_clock;
        return 1'b0;
      end
      if (line_tag[slot] == tag) begin
        line_stamp[slot] = access_clock;
        return 1'b1;
      end
      // Oldest way so far; ties keep the lower way.
      age = access_clock - line_stamp[slot];
      if (!have_victim || age > oldest_age) begin
        have_victim = 1'b1;
        oldest_age  = age;
        victim      = slot;
      end
    end
    evict            = 1'b1;
    line_tag[victim]   = tag;
    line_stamp[victim] = access_clock;
    return 1'b0;
  endfunction

  // Work out the result of one accepted load, store or modify.
  function automatic access_result_t predict_access(opcode_t op, logic [ADDR_W-1:0] a);
    access_result_t r;
    bit             first_hit, second_hit, ev, ev_unused;
    second_hit = 1'b0;
    first_hit  = cache_lookup(a, ev);
    if (op == OP_MODIFY)
      second_hit = cache_lookup(a, ev_unused);
    r.hits      = {1'b0, first_hit} + {1'b0, second_hit};
    r.missed    = !first_hit;
    r.evicted   = ev;
    hit_total   = hit_total + TOTAL_W'(r.hits);
    miss_total  = miss_total + TOTAL_W'(r.missed);
    evict_total = evict_total + TOTAL_W'(ev);
    access_clock = access_clock + 1;
    r.total_hits      = hit_total;
    r.total_misses    = miss_total;
    r.total_evictions = evict_total;
    return r;
  endfunction

  // Build an address from tag, set and offset under the current geometry.
  function automatic logic [ADDR_W-1:0] place_address(logic [ADDR_W-1:0] tag,
                                                      int unsigned set_idx,
                                                      logic [ADDR_W-1:0] off);
    int unsigned       sb, ob;
    logic [ADDR_W-1:0] one, set_v;
    sb    = active_set_bits();
    ob    = 32'(cfg_offset_bits);
    one   = ADDR_W'(1);
    set_v = ADDR_W'(set_idx);
    return (tag << (sb + ob)) | ((set_v & ((one << sb) - one)) << ob) |
           (off & ((one << ob) - one));
  endfunction

  // Present one request and hold it until it is taken.
  task automatic send_request(opcode_t op, logic [ADDR_W-1:0] a);
    in_valid <= 1'b1;
    opcode   <= op;
    address  <= a;
    do @(posedge clk); while (in_stall);
    if (op != OP_IFETCH)
      pending_results.push_back(predict_access(op, a));
  endtask

  // Send a request, then open a gap in the request stream when a burst ends.
  task automatic issue(opcode_t op, logic [ADDR_W-1:0] a);
    int unsigned gap;
    send_request(op, a);
    if (burst_left > 0)
      burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 12);
    end
  endtask

  // Stop sending and wait until the block has delivered everything and gone quiet.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_SET_BITS:    cfg_set_bits    = value[2:0];
      REG_OFFSET_BITS: cfg_offset_bits = value[4:0];
      REG_WAYS:        cfg_ways        = value[2:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Change the geometry once the block is idle; cached lines are kept.
  task automatic configure(int unsigned sb, int unsigned ob, int unsigned ways);
    drain_results();
    write_reg(REG_SET_BITS, CFG_DATA_W'(sb));
    write_reg(REG_OFFSET_BITS, CFG_DATA_W'(ob));
    write_reg(REG_WAYS, CFG_DATA_W'(ways));
  endtask

  // Fills, hits, stores acting as loads, and fetches that leave the cache alone.
  task automatic test_fills_and_hits();
    issue(OP_LOAD,   place_address(0, 0, 0));
    issue(OP_LOAD,   place_address(0, 0, 0));
    issue(OP_STORE,  place_address(0, 0, 15));
    issue(OP_IFETCH, place_address(5, 0, 0));
    issue(OP_LOAD,   place_address(5, 0, 0));
  endtask

  // Modify: a missing line is filled then hit, a present line hits twice.
  task automatic test_modify();
    issue(OP_MODIFY, place_address(1, 3, 2));
    issue(OP_MODIFY, place_address(1, 3, 2));
  endtask

  // Fill one set, refresh a line, then force replacements in age order.
  task automatic test_lru_eviction();
    for (int t = 10; t < 14; t++)
      issue(OP_LOAD, place_address(ADDR_W'(t), 7, 0));
    issue(OP_LOAD,   place_address(10, 7, 4));
    issue(OP_LOAD,   place_address(14, 7, 0));
    issue(OP_LOAD,   place_address(11, 7, 0));
    issue(OP_MODIFY, place_address(15, 7, 0));
  endtask

  task automatic test_address_extremes();
    issue(OP_LOAD,   48'hFFFF_FFFF_FFFF);
    issue(OP_LOAD,   48'h0000_0000_0000);
    issue(OP_LOAD,   48'h8000_0000_0000);
    issue(OP_STORE,  48'hFFFF_FFFF_FFFF);
    issue(OP_MODIFY, 48'h7FFF_FFFF_FFFF);
  endtask

  // Oversized set bits, widest offset, zero ways and oversized ways.
  task automatic test_register_extremes();
    configure(7, 31, 0);
    issue(OP_LOAD, place_address(3, 60, 9));
    issue(OP_LOAD, place_address(3, 60, 9));
    issue(OP_LOAD, place_address(4, 60, 9));
    configure(0, 0, 7);
    issue(OP_STORE, 48'h0000_0000_0123);
  endtask

  // Random traffic under one geometry; most requests reuse a small pool of lines.
  task automatic run_phase(int unsigned sb, int unsigned ob, int unsigned ways,
                           int unsigned count);
    logic [ADDR_W-1:0] tag_base, a;
    int unsigned       set_base, pool, sent, pick;
    opcode_t           op;
    configure(sb, ob, ways);
    tag_base = ADDR_W'({$urandom, $urandom});
    if ($urandom_range(0, 1) == 0)
      tag_base = ADDR_W'($urandom_range(0, 15));
    set_base = $urandom_range(0, 63);
    pool     = ((ways == 0) ? 1 : ((ways > WAYS_N) ? WAYS_N : ways)) + 3;
    sent     = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      op   = opcode_t'($urandom_range(0, 2));
      if (pick < 8) begin
        a = ADDR_W'({$urandom, $urandom});
        issue(OP_IFETCH, a);
      end else begin
        if (pick < 20)
          a = ADDR_W'({$urandom, $urandom});
        else
          a = place_address(tag_base + ADDR_W'($urandom_range(0, pool - 1)),
                            set_base + $urandom_range(0, 3),
                            ADDR_W'({$urandom, $urandom}));
        issue(op, a);
        sent++;
      end
    end
  endtask

  task automatic test_random_traffic();
    int unsigned phase_sb   [10] = '{4, 0, 6, 7, 2, 3, 1, 5, 6, 0};
    int unsigned phase_ob   [10] = '{4, 0, 31, 4, 3, 0, 12, 20, 0, 31};
    int unsigned phase_ways [10] = '{4, 1, 4, 0, 2, 7, 3, 5, 4, 4};
    for (int p = 0; p < 10; p++)
      run_phase(phase_sb[p], phase_ob[p], phase_ways[p], 100);
    for (int p = 0; p < 3; p++)
      run_phase($urandom_range(0, 7), $urandom_range(0, 31), $urandom_range(0, 7), 100);
  endtask

  task automatic note_mismatch(string field, longint unsigned exp_v, longint unsigned act_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("MISMATCH %s: expected %0d, got %0d at %0t", field, exp_v, act_v, $time);
  endtask

  // Compare each delivered result with the oldest prediction, and drive the stall pattern.
  always @(posedge clk) begin
    access_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("MISMATCH: result with none outstanding at %0t", $time);
      end else begin
        exp_r = pending_results.pop_front();
        if (hits !== exp_r.hits)
          note_mismatch("hits", exp_r.hits, hits);
        if (missed !== exp_r.missed)
          note_mismatch("missed", exp_r.missed, missed);
        if (evicted !== exp_r.evicted)
          note_mismatch("evicted", exp_r.evicted, evicted);
        if (total_hits !== exp_r.total_hits)
          note_mismatch("total_hits", exp_r.total_hits, total_hits);
        if (total_misses !== exp_r.total_misses)
          note_mismatch("total_misses", exp_r.total_misses, total_misses);
        if (total_evictions !== exp_r.total_evictions)
          note_mismatch("total_evictions", exp_r.total_evictions, total_evictions);
      end
    end
    // Receiver alternates between no stall, random, periodic and heavy stalling.
    stall_tick++;
    if (stall_tick % 256 == 0)
      stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 2) == 0);
      2:       out_stall <= ((stall_tick % 9) >= 5);
      default: out_stall <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // Main sequence.
  initial begin
    reset_model();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fills_and_hits();
    test_modify();
    test_lru_eviction();
    test_address_extremes();
    test_register_extremes();
    test_random_traffic();
    drain_results();
    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #10ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
